// ----- design/matrix_inverse_adjugate_macros.svh -----
// Assertion shorthands for the checker file of this block.
`ifndef MATRIX_INVERSE_ADJUGATE_MACROS_SVH
`define MATRIX_INVERSE_ADJUGATE_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define MIA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define MIA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mia_pkg;

   // Matrix and number formats.
   localparam int MAX_ORDER = 4;
   localparam int ELEM_W    = 12;
   localparam int ORDER_W   = 3;
   localparam int ENTRY_W   = 32;
   localparam int DETQ_W    = 48;
   localparam int COF_W     = 40;
   localparam int DET_W     = 52;
   localparam int QUO_W     = 33;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 80;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;

   // Controller states.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_COF_CLR,
      ST_COF,
      ST_COF_SAVE,
      ST_DET_CLR,
      ST_DET_FETCH,
      ST_DET_ACC,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_OUT,
      ST_EMIT
   } state_type;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_COF_CLR,
      DP_COF_FETCH,
      DP_COF_SAVE,
      DP_DET_CLR,
      DP_DET_FETCH,
      DP_DET_ACC,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_OUT
   } dp_op_type;

   // Command bundle from the controller to the datapath.
   typedef struct packed {
      dp_op_type    op;
      logic [2:0]   order_n;
      logic [3:0]   waddr;
      logic [1:0]   ci;
      logic [1:0]   cj;
      logic [2:0]   term;
      logic [1:0]   phase;
      logic [1:0]   er;
      logic [1:0]   ec;
      logic         last;
   } ctl_type;

endpackage

`default_nettype wire

// ----- design/matrix_inverse_adjugate.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Matrix inverse by adjugate. Write the order (1 to 4) on csr_wdata with csr_we,
// then stream the n*n Q4.8 elements row by row, one request per cycle. After the
// last element the block stops taking requests: it forms all n*n cofactors by
// the Sarrus rule, sums the first row into the determinant, and then produces
// each inverse entry in Q15.16 through a 33-step restoring divider; it starts
// the next entry only once the current one is taken. Every result carries the
// determinant in Q31.16 and the singular and clipped flags; tlast marks the
// last entry.
module matrix_inverse_adjugate (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [mia_pkg::ORDER_W-1:0] csr_wdata,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [mia_pkg::REQ_W-1:0]   req_tdata,   // element[11:0]
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [mia_pkg::RSP_W-1:0]        rsp_tdata,   // inverse_entry[31:0], determinant[79:32]
   output logic [1:0]                       rsp_tuser,   // singular[0], clipped[1]
   output logic                             rsp_tlast
);
   import mia_pkg::*;

   ctl_type                    ctl;
   logic signed [ENTRY_W-1:0]  inverse_entry;
   logic signed [DETQ_W-1:0]   determinant;
   logic                       singular, clipped;

   mia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   mia_dpath u_dpath (
      .clock         (clock),
      .ctl           (ctl),
      .element       (req_tdata[ELEM_W-1:0]),
      .inverse_entry (inverse_entry),
      .determinant   (determinant),
      .singular      (singular),
      .clipped       (clipped),
      .final_res     (rsp_tlast)
   );

   assign rsp_tdata = {determinant, inverse_entry};
   assign rsp_tuser = {clipped, singular};

endmodule

`default_nettype wire

// ----- design/mia_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mia_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [mia_pkg::ORDER_W-1:0] csr_wdata,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output mia_pkg::ctl_type                 ctl
);
   import mia_pkg::*;

   state_type            state_ff, state_in;
   logic [ORDER_W-1:0]   order_ff, order_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [1:0]           ci_ff, ci_in, cj_ff, cj_in, er_ff, er_in, ec_ff, ec_in;
   logic [2:0]           term_ff, term_in;
   logic [1:0]           phase_ff, phase_in;
   logic [5:0]           step_ff, step_in;
   logic [2:0]           n;
   logic [4:0]           total;
   logic                 accept, load_last, cof_last, det_last, ent_last;

   // Effective order: zero acts as one, anything above the maximum as the maximum.
   always_comb begin
      if (order_ff == '0) begin
         n = 3'd1;
      end else if (order_ff > 3'(MAX_ORDER)) begin
         n = 3'(MAX_ORDER);
      end else begin
         n = order_ff;
      end
   end

   assign total     = 5'(n) * 5'(n);
   assign accept    = req_tvalid && req_tready;
   assign load_last = (5'(cnt_ff) == total - 5'd1);
   assign cof_last  = (3'(ci_ff) == n - 3'd1) && (3'(cj_ff) == n - 3'd1);
   assign det_last  = (3'(cj_ff) == n - 3'd1);
   assign ent_last  = (3'(er_ff) == n - 3'd1) && (3'(ec_ff) == n - 3'd1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:      if (accept && load_last) state_in = ST_COF_CLR;
         ST_COF_CLR:   state_in = ST_COF;
         ST_COF:       if (term_ff == 3'd5 && phase_ff == 2'd3) state_in = ST_COF_SAVE;
         ST_COF_SAVE:  state_in = cof_last ? ST_DET_CLR : ST_COF_CLR;
         ST_DET_CLR:   state_in = ST_DET_FETCH;
         ST_DET_FETCH: state_in = ST_DET_ACC;
         ST_DET_ACC:   state_in = det_last ? ST_DIV_INIT : ST_DET_FETCH;
         ST_DIV_INIT:  state_in = ST_DIV_STEP;
         ST_DIV_STEP:  if (step_ff == 6'(QUO_W - 1)) state_in = ST_OUT;
         ST_OUT:       state_in = ST_EMIT;
         ST_EMIT:      if (rsp_tready) state_in = ent_last ? ST_LOAD : ST_DIV_INIT;
         default:      state_in = ST_LOAD;
      endcase
   end

   // Counters and the order register.
   always_comb begin
      order_in = order_ff;
      cnt_in   = cnt_ff;
      ci_in    = ci_ff;
      cj_in    = cj_ff;
      er_in    = er_ff;
      ec_in    = ec_ff;
      term_in  = term_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cnt_in = load_last ? 4'd0 : cnt_ff + 4'd1;
               ci_in  = 2'd0;
               cj_in  = 2'd0;
            end
         end
         ST_COF_CLR: begin
            term_in  = 3'd0;
            phase_in = 2'd0;
         end
         ST_COF: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) term_in = term_ff + 3'd1;
         end
         ST_COF_SAVE: begin
            if (3'(cj_ff) == n - 3'd1) begin
               cj_in = 2'd0;
               ci_in = ci_ff + 2'd1;
            end else begin
               cj_in = cj_ff + 2'd1;
            end
            if (cof_last) begin
               cj_in = 2'd0;
            end
         end
         ST_DET_CLR:   cj_in = 2'd0;
         ST_DET_FETCH: cj_in = cj_ff;
         ST_DET_ACC: begin
            cj_in = cj_ff + 2'd1;
            er_in = 2'd0;
            ec_in = 2'd0;
         end
         ST_DIV_INIT:  step_in = 6'd0;
         ST_DIV_STEP:  step_in = step_ff + 6'd1;
         ST_OUT:       step_in = step_ff;
         ST_EMIT: begin
            if (rsp_tready) begin
               if (3'(ec_ff) == n - 3'd1) begin
                  ec_in = 2'd0;
                  er_in = er_ff + 2'd1;
               end else begin
                  ec_in = ec_ff + 2'd1;
               end
            end
         end
         default: cnt_in = 4'd0;
      endcase
      // An order write drops any partly loaded matrix.
      if (csr_we) begin
         order_in = csr_wdata;
         cnt_in   = 4'd0;
      end
   end

   // Outputs.
   always_comb begin
      ctl.order_n = n;
      ctl.waddr   = cnt_ff;
      ctl.ci      = ci_ff;
      ctl.cj      = cj_ff;
      ctl.term    = term_ff;
      ctl.phase   = phase_ff;
      ctl.er      = er_ff;
      ctl.ec      = ec_ff;
      ctl.last    = ent_last;
      req_tready  = (state_ff == ST_LOAD);
      rsp_tvalid  = (state_ff == ST_EMIT);
      unique case (state_ff)
         ST_LOAD:      ctl.op = accept ? DP_LOAD : DP_IDLE;
         ST_COF_CLR:   ctl.op = DP_COF_CLR;
         ST_COF:       ctl.op = DP_COF_FETCH;
         ST_COF_SAVE:  ctl.op = DP_COF_SAVE;
         ST_DET_CLR:   ctl.op = DP_DET_CLR;
         ST_DET_FETCH: ctl.op = DP_DET_FETCH;
         ST_DET_ACC:   ctl.op = DP_DET_ACC;
         ST_DIV_INIT:  ctl.op = DP_DIV_INIT;
         ST_DIV_STEP:  ctl.op = DP_DIV_STEP;
         ST_OUT:       ctl.op = DP_OUT;
         default:      ctl.op = DP_IDLE;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         order_ff <= ORDER_RESET;
         cnt_ff   <= 4'd0;
         ci_ff    <= 2'd0;
         cj_ff    <= 2'd0;
         er_ff    <= 2'd0;
         ec_ff    <= 2'd0;
         term_ff  <= 3'd0;
         phase_ff <= 2'd0;
         step_ff  <= 6'd0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         cnt_ff   <= cnt_in;
         ci_ff    <= ci_in;
         cj_ff    <= cj_in;
         er_ff    <= er_in;
         ec_ff    <= ec_in;
         term_ff  <= term_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/mia_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mia_dpath (
   input  wire logic                              clock,
   input  wire mia_pkg::ctl_type                  ctl,
   input  wire logic signed [mia_pkg::ELEM_W-1:0] element,
   output logic signed [mia_pkg::ENTRY_W-1:0]     inverse_entry,
   output logic signed [mia_pkg::DETQ_W-1:0]      determinant,
   output logic                                   singular,
   output logic                                   clipped,
   output logic                                   final_res
);
   import mia_pkg::*;

   logic signed [ELEM_W-1:0] mat_mem [16];
   logic signed [COF_W-1:0]  cof_mem [16];

   logic signed [ELEM_W-1:0] rd_ff;
   logic                     isc_ff, cval_ff;
   logic signed [ELEM_W-1:0] operand;
   logic signed [ELEM_W-1:0] xr_ff;
   logic signed [2*ELEM_W-1:0] prod_ff;
   logic signed [3*ELEM_W-1:0] p3;
   logic signed [COF_W-1:0]  acc_ff;
   logic signed [DET_W-1:0]  det_ff;
   logic signed [DET_W-1:0]  dprod;
   logic [DET_W:0]           rem_ff, rem2;
   logic [QUO_W-1:0]         nlo_ff, q_ff;
   logic                     neg_ff, ov_ff;

   logic [1:0]  slot, mr, mc, off, i, j;
   logic [2:0]  sr, sc;
   logic [5:0]  cols;
   logic        isc, cval, term_neg;
   logic [3:0]  raddr, cidx;
   logic signed [COF_W-1:0] cof_rd;
   logic [COF_W-1:0]        cof_abs;
   logic [63:0]             num_abs;
   logic [DET_W-1:0]        dabs;
   logic signed [DET_W-1:0] dq;
   logic                    sing, dclip, eclip;
   logic signed [ENTRY_W-1:0] entry;
   logic signed [DETQ_W-1:0]  dsat;

   // Column picked by each row of a Sarrus term, and the sign of that term.
   always_comb begin
      unique case (ctl.term)
         3'd0:    cols = {2'd2, 2'd1, 2'd0};
         3'd1:    cols = {2'd0, 2'd2, 2'd1};
         3'd2:    cols = {2'd1, 2'd0, 2'd2};
         3'd3:    cols = {2'd0, 2'd1, 2'd2};
         3'd4:    cols = {2'd2, 2'd0, 2'd1};
         3'd5:    cols = {2'd1, 2'd2, 2'd0};
         default: cols = 6'd0;
      endcase
      term_neg = (ctl.term >= 3'd3);
   end

   // The minor of order n-1 sits in the lower right of a 3x3 frame whose
   // upper left is the identity, so one 3x3 determinant serves every order.
   always_comb begin
      slot  = (ctl.phase == 2'd3) ? 2'd2 : ctl.phase;
      mr    = slot;
      mc    = cols[2*slot +: 2];
      off   = 2'(3'd4 - ctl.order_n);
      i     = mr - off;
      j     = mc - off;
      sr    = 3'(i) + ((i >= ctl.ci) ? 3'd1 : 3'd0);
      sc    = 3'(j) + ((j >= ctl.cj) ? 3'd1 : 3'd0);
      isc   = 1'b0;
      cval  = 1'b0;
      raddr = 4'(4'(sr) * 4'(ctl.order_n) + 4'(sc));
      if (ctl.op == DP_DET_FETCH) begin
         raddr = 4'(ctl.cj);
      end else if (mr < off || mc < off) begin
         isc  = 1'b1;
         cval = (mr == mc);
      end
   end

   // Matrix memory: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.op == DP_LOAD) begin
         mat_mem[ctl.waddr] <= element;
      end
      rd_ff   <= mat_mem[raddr];
      isc_ff  <= isc;
      cval_ff <= cval;
   end

   assign operand = isc_ff ? ELEM_W'(cval_ff) : rd_ff;
   assign p3      = prod_ff * operand;

   // Cofactor read: row zero for the determinant, transposed for the inverse.
   assign cidx    = (ctl.op == DP_DIV_INIT) ? {ctl.ec, ctl.er} : {2'd0, ctl.cj};
   assign cof_rd  = cof_mem[cidx];
   assign cof_abs = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : COF_W'(cof_rd);
   assign num_abs = {cof_abs, 24'd0};
   assign dabs    = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
   assign rem2    = {rem_ff[DET_W-1:0], nlo_ff[QUO_W-1]};

   // First-row term of the determinant, formed at full determinant width.
   assign dprod   = operand * cof_rd;

   // Cofactor, determinant and restoring division.
   always_ff @(posedge clock) begin
      unique case (ctl.op)
         DP_COF_CLR: acc_ff <= '0;
         DP_COF_FETCH: begin
            if (ctl.phase == 2'd1) xr_ff <= operand;
            if (ctl.phase == 2'd2) prod_ff <= xr_ff * operand;
            if (ctl.phase == 2'd3) begin
               acc_ff <= term_neg ? acc_ff - COF_W'(p3) : acc_ff + COF_W'(p3);
            end
         end
         DP_COF_SAVE: begin
            cof_mem[{ctl.ci, ctl.cj}] <= (ctl.ci[0] ^ ctl.cj[0]) ? -acc_ff : acc_ff;
         end
         DP_DET_CLR: det_ff <= '0;
         DP_DET_ACC: det_ff <= det_ff + dprod;
         DP_DIV_INIT: begin
            neg_ff <= cof_rd[COF_W-1] ^ det_ff[DET_W-1];
            ov_ff  <= (DET_W'(num_abs[63:QUO_W]) >= dabs);
            rem_ff <= (DET_W+1)'(num_abs[63:QUO_W]);
            nlo_ff <= num_abs[QUO_W-1:0];
            q_ff   <= '0;
         end
         DP_DIV_STEP: begin
            nlo_ff <= {nlo_ff[QUO_W-2:0], 1'b0};
            if (rem2 >= (DET_W+1)'(dabs)) begin
               rem_ff <= rem2 - (DET_W+1)'(dabs);
               q_ff   <= {q_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem2;
               q_ff   <= {q_ff[QUO_W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // Determinant rescaled to 16 fraction bits, truncated toward zero, and saturated to the output width.
   always_comb begin
      unique case (ctl.order_n)
         3'd1:    dq = det_ff <<< 8;
         3'd2:    dq = det_ff;
         3'd3:    dq = (det_ff + (det_ff[DET_W-1] ? DET_W'(255) : DET_W'(0))) >>> 8;
         default: dq = (det_ff + (det_ff[DET_W-1] ? DET_W'(65535) : DET_W'(0))) >>> 16;
      endcase
      dclip = (dq[DET_W-1:DETQ_W-1] != '0) && (dq[DET_W-1:DETQ_W-1] != '1);
      if (!dclip) begin
         dsat = DETQ_W'(dq);
      end else if (dq[DET_W-1]) begin
         dsat = {1'b1, {(DETQ_W-1){1'b0}}};
      end else begin
         dsat = {1'b0, {(DETQ_W-1){1'b1}}};
      end
   end

   // Quotient sign and saturation; a singular matrix gives zero.
   always_comb begin
      sing  = (det_ff == '0);
      eclip = 1'b0;
      entry = '0;
      if (sing) begin
         entry = '0;
      end else if (ov_ff || (neg_ff && q_ff > 33'h080000000) ||
                   (!neg_ff && q_ff > 33'h07FFFFFFF)) begin
         eclip = 1'b1;
         entry = neg_ff ? {1'b1, {(ENTRY_W-1){1'b0}}} : {1'b0, {(ENTRY_W-1){1'b1}}};
      end else if (neg_ff) begin
         entry = ENTRY_W'(-q_ff);
      end else begin
         entry = ENTRY_W'(q_ff);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (ctl.op == DP_OUT) begin
         inverse_entry <= entry;
         determinant   <= dsat;
         singular      <= sing;
         clipped       <= dclip | eclip;
         final_res     <= ctl.last;
      end
   end

endmodule

`default_nettype wire

// ----- design/mia_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_inverse_adjugate_macros.svh"

module mia_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [79:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser,
   input wire logic         rsp_tlast
);

   // A stalled result holds its payload.
   `MIA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed under stall")

   // Loading and emitting never overlap.
   `MIA_ASSERT_IMP(a_one_side, clock, reset, rsp_tvalid, !req_tready, "request taken while emitting")

   // A singular matrix gives zero entries.
   `MIA_ASSERT_IMP(a_sing_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[31:0] == 32'd0, "nonzero entry for singular matrix")

   // After the last entry the block loads again.
   `MIA_ASSERT_NXT(a_back_to_load, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready && !rsp_tvalid, "no return to loading")

endmodule

bind matrix_inverse_adjugate mia_checker u_mia_checker (.*);

`default_nettype wire
